### hdl/utf8_name_validator_core_defines.svh
// assertion macros used by the validator top level
`ifndef UTF8_NAME_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_NAME_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication
`define UTF8NV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8nv check failed");

// next-cycle implication
`define UTF8NV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8nv check failed");

`endif

### hdl/utf8nv_pkg.sv
// types, constants and helper functions of the utf-8 name validator
`default_nettype none
package utf8nv_pkg;

   localparam int unsigned LenWidth   = 8;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned CpWidth    = 21;

   localparam logic [LenWidth-1:0]   MaxLengthReset = 8'd48;
   localparam logic [CountWidth-1:0] CountSat       = 9'd511;

   localparam logic [7:0] AsciiDel   = 8'h7f;
   localparam logic [7:0] AsciiSpace = 8'h20;
   localparam logic [7:0] Lead2Lo    = 8'hc2;
   localparam logic [7:0] Lead2Hi    = 8'hdf;
   localparam logic [7:0] Lead3Lo    = 8'he0;
   localparam logic [7:0] Lead3Hi    = 8'hef;
   localparam logic [7:0] Lead4Lo    = 8'hf0;
   localparam logic [7:0] Lead4Hi    = 8'hf4;

   localparam logic [CpWidth-1:0] CpMax       = 21'h10ffff;
   localparam logic [CpWidth-1:0] SurrLo      = 21'h00d800;
   localparam logic [CpWidth-1:0] SurrHi      = 21'h00dfff;
   localparam logic [CpWidth-1:0] C1Lo        = 21'h000080;
   localparam logic [CpWidth-1:0] C1Hi        = 21'h00009f;
   localparam logic [CpWidth-1:0] Floor2      = 21'h000080;
   localparam logic [CpWidth-1:0] Floor3      = 21'h000800;
   localparam logic [CpWidth-1:0] Floor4      = 21'h010000;

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_TWO   = 2'd1,
      CLS_THREE = 2'd2,
      CLS_FOUR  = 2'd3
   } seq_class_type;

   typedef struct packed {
      logic                  error_seen;
      logic [1:0]            pending;
      logic [CpWidth-1:0]    accum;
      seq_class_type         min_class;
      logic [CountWidth-1:0] byte_count;
   } utf8nv_state_type;

   typedef struct packed {
      logic ok_so_far;
      logic end_of_string;
      logic verdict;
   } utf8nv_result_type;

   function automatic logic code_point_bad(input logic [CpWidth-1:0] cp,
                                           input seq_class_type cls);
      logic [CpWidth-1:0] floor_cp;
      logic               bad;
      unique case (cls)
         CLS_TWO:   floor_cp = Floor2;
         CLS_THREE: floor_cp = Floor3;
         default:   floor_cp = Floor4;
      endcase
      bad = (cp < floor_cp) || (cp > CpMax)
         || ((cp >= SurrLo) && (cp <= SurrHi))
         || ((cp >= C1Lo) && (cp <= C1Hi));
      return bad;
   endfunction

endpackage
`default_nettype wire

### hdl/utf8nv_step.sv
// per-byte utf-8 decode, length check and state update
`default_nettype none
module utf8nv_step
   import utf8nv_pkg::*;
(
   input  utf8nv_state_type    state,
   input  logic [7:0]          data_byte,
   input  logic                last,
   input  logic [LenWidth-1:0] max_length,
   output utf8nv_state_type    state_in,
   output utf8nv_result_type   result
);

   utf8nv_state_type   upd;
   logic [CpWidth-1:0] accum_shift;
   logic [1:0]         pending_dec;

   assign accum_shift = {state.accum[CpWidth-7:0], data_byte[5:0]};
   assign pending_dec = state.pending - 2'd1;

   always_comb begin
      upd = state;
      if (state.byte_count != CountSat) begin
         upd.byte_count = state.byte_count + 9'd1;
      end
      if (upd.byte_count > {1'b0, max_length}) begin
         upd.error_seen = 1'b1;
      end

      if (state.pending == 2'd0) begin
         priority if (!data_byte[7]) begin
            if ((data_byte < AsciiSpace) || (data_byte == AsciiDel)) begin
               upd.error_seen = 1'b1;
            end
         end else if ((data_byte >= Lead2Lo) && (data_byte <= Lead2Hi)) begin
            upd.pending   = 2'd1;
            upd.min_class = CLS_TWO;
            upd.accum     = {16'd0, data_byte[4:0]};
         end else if ((data_byte >= Lead3Lo) && (data_byte <= Lead3Hi)) begin
            upd.pending   = 2'd2;
            upd.min_class = CLS_THREE;
            upd.accum     = {17'd0, data_byte[3:0]};
         end else if ((data_byte >= Lead4Lo) && (data_byte <= Lead4Hi)) begin
            upd.pending   = 2'd3;
            upd.min_class = CLS_FOUR;
            upd.accum     = {18'd0, data_byte[2:0]};
         end else begin
            upd.error_seen = 1'b1;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         // bad continuation abandons the open sequence
         upd.error_seen = 1'b1;
         upd.pending    = 2'd0;
         upd.accum      = '0;
         upd.min_class  = CLS_NONE;
      end else begin
         upd.accum   = accum_shift;
         upd.pending = pending_dec;
         if (pending_dec == 2'd0) begin
            if (code_point_bad(accum_shift, state.min_class)) begin
               upd.error_seen = 1'b1;
            end
            upd.accum     = '0;
            upd.min_class = CLS_NONE;
         end
      end

      if (last && (upd.pending != 2'd0)) begin
         upd.error_seen = 1'b1;
      end
   end

   assign result.ok_so_far     = !upd.error_seen;
   assign result.end_of_string = last;
   assign result.verdict       = last && !upd.error_seen;

   assign state_in = last ? '0 : upd;

endmodule
`default_nettype wire

### hdl/utf8_name_validator_core.sv
// top level of the utf-8 display-name validator
// Streams a name one byte per beat (last byte flagged) and returns one result beat
// per byte: ok_so_far, an echo of last, and on the last byte the verdict for the whole
// string. Throughput is one byte per clock while the result side is not stalled; a
// byte is held in the input register once accepted, and its result is loaded into the
// output register that drives rsp_valid when the result side can take it. The rate is
// set by the per-byte decode state update, a combinational path from the state register
// back to itself. max_length (reset 48) may only be written while no string is in flight.
`default_nettype none
`include "utf8_name_validator_core_defines.svh"
module utf8_name_validator_core
   import utf8nv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok_so_far,
   output logic                rsp_end_of_string,
   output logic                rsp_verdict,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LenWidth-1:0] csr_max_length
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   utf8nv_result_type   rsp_ff;
   logic [LenWidth-1:0] max_length_ff;
   utf8nv_state_type    state_ff, state_in;
   utf8nv_state_type    step_state;
   utf8nv_result_type   step_result;
   logic                advance;
   logic                req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign state_in     = advance ? step_state : state_ff;

   utf8nv_step u_step (
      .state      (state_ff),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .max_length (max_length_ff),
      .state_in   (step_state),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         max_length_ff <= MaxLengthReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         if (csr_valid) begin
            max_length_ff <= csr_max_length;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok_so_far     = rsp_ff.ok_so_far;
   assign rsp_end_of_string = rsp_ff.end_of_string;
   assign rsp_verdict       = rsp_ff.verdict;

   `UTF8NV_ASSERT_NOW(a_verdict_implies_ok, clock, reset, rsp_valid_ff && rsp_ff.verdict, rsp_ff.end_of_string && rsp_ff.ok_so_far)
   `UTF8NV_ASSERT_NEXT(a_state_clear_after_last, clock, reset, advance && in_last_ff, state_ff == '0)
   `UTF8NV_ASSERT_NEXT(a_error_sticky, clock, reset, state_ff.error_seen && !(advance && in_last_ff), state_ff.error_seen)
   `UTF8NV_ASSERT_NOW(a_pending_has_class, clock, reset, state_ff.pending != 2'd0, state_ff.min_class != CLS_NONE)

endmodule
`default_nettype wire
